FILE: sv/hlom_pkg.sv
package hlom_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int ANGLE_BITS = 16;
	localparam int YAW_BITS = 16;
	localparam int PHASE_BITS = ANGLE_BITS - 2;
	localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SINE_BITS = 15;
	localparam int STICK_BITS = 11;
	localparam int CFG_BITS = 16;
	localparam int SPEED_BITS = 16;
	localparam int NUM_STAGES = 10;

	localparam int AXIS_BITS = STICK_BITS + 1;
	localparam int TRIG_BITS = SINE_BITS + 1;
	localparam int PROD_BITS = AXIS_BITS + TRIG_BITS;
	localparam int VEL_BITS = PROD_BITS;
	localparam int MIX_BITS = VEL_BITS + 1;
	localparam int KPROD_BITS = MIX_BITS + 16;
	localparam int SPIN_BITS = AXIS_BITS + CFG_BITS + 1;
	localparam int SPIN_SHIFT = 14;
	localparam int SUM_BITS = KPROD_BITS + 1;
	localparam int LO_BITS = 23;
	localparam int HI_BITS = SUM_BITS - LO_BITS;
	localparam int LO_PROD_BITS = LO_BITS + CFG_BITS;
	localparam int HI_PROD_BITS = HI_BITS + CFG_BITS + 1;
	localparam int FULL_BITS = HI_PROD_BITS + LO_BITS;
	localparam int MAG_BITS = FULL_BITS - 1;
	localparam int ROUND_SHIFT = 38;
	localparam int QUOT_BITS = MAG_BITS - ROUND_SHIFT + 1;

	localparam logic signed [15:0] MIX_K_Q15 = 16'sd23170;
	localparam logic [CFG_BITS-1:0] RADIUS_RESET = 16'd12452;
	localparam logic [CFG_BITS-1:0] INV_SPACING_RESET = 16'd3413;

	localparam logic REG_WHEEL_RADIUS = 1'b0;
	localparam logic REG_INV_SPACING = 1'b1;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint SINE_FULL = 64'sd32767;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} stage_ctl_t;

	typedef logic [SINE_BITS-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	function automatic longint taylor_div(longint t, int n);
		longint r;
		unique case (n)
			1: r = t / 6;
			2: r = t / 20;
			3: r = t / 42;
			4: r = t / 72;
			5: r = t / 110;
			6: r = t / 156;
			default: r = t / 210;
		endcase
		return r;
	endfunction

	function automatic logic [SINE_BITS-1:0] quarter_sine(int k);
		longint x;
		longint x2;
		longint term;
		longint sum;
		x = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
		x2 = (x * x) / Q30_ONE;
		term = x;
		sum = x;
		for (int n = 1; n <= 7; n++) begin
			term = (term * x2) / Q30_ONE;
			term = taylor_div(term, n);
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum * SINE_FULL + (longint'(1) <<< 29)) >>> 30;
		if (sum > SINE_FULL) begin
			sum = SINE_FULL;
		end
		return SINE_BITS'(sum);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			rom[k] = quarter_sine(k);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: sv/hlom_if.sv
interface hlom_in_if;
	import hlom_pkg::*;
	logic valid;
	logic ready;
	logic signed [STICK_BITS-1:0] stick_forward;
	logic signed [STICK_BITS-1:0] stick_lateral;
	logic signed [STICK_BITS-1:0] stick_turn;
	logic [YAW_BITS-1:0] yaw_angle;

	modport source(output valid, stick_forward, stick_lateral, stick_turn, yaw_angle,
		input ready);
	modport sink(input valid, stick_forward, stick_lateral, stick_turn, yaw_angle,
		output ready);
endinterface

interface hlom_out_if;
	import hlom_pkg::*;
	logic valid;
	logic ready;
	logic signed [SPEED_BITS-1:0] wheel_one_speed;
	logic signed [SPEED_BITS-1:0] wheel_two_speed;
	logic signed [SPEED_BITS-1:0] wheel_three_speed;
	logic signed [SPEED_BITS-1:0] wheel_four_speed;

	modport source(output valid, wheel_one_speed, wheel_two_speed, wheel_three_speed,
		wheel_four_speed, input ready);
	modport sink(input valid, wheel_one_speed, wheel_two_speed, wheel_three_speed,
		wheel_four_speed, output ready);
endinterface

FILE: sv/hlom_ctrl.sv
module hlom_ctrl import hlom_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output logic       in_ready,
	output stage_ctl_t ctl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0] adv;
	logic [NUM_STAGES-1:0] prev;

	always_comb begin
		adv[NUM_STAGES] = out_ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign prev = {vld_q[NUM_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= prev[k];
				end
			end
		end
	end

	assign in_ready = adv[0];
	assign ctl.load = adv[NUM_STAGES-1:0];
	assign ctl.valid = vld_q;

endmodule

FILE: sv/hlom_rotate.sv
module hlom_rotate import hlom_pkg::*; (
	input  logic                         clk,
	input  stage_ctl_t                   ctl,
	input  logic signed [STICK_BITS-1:0] stick_forward,
	input  logic signed [STICK_BITS-1:0] stick_lateral,
	input  logic signed [STICK_BITS-1:0] stick_turn,
	input  logic [YAW_BITS-1:0]          yaw_angle,
	input  logic [CFG_BITS-1:0]          wheel_radius_factor,
	output logic signed [VEL_BITS-1:0]   vx_s4,
	output logic signed [VEL_BITS-1:0]   vy_s4,
	output logic signed [SPIN_BITS-1:0]  spin_s4
);

	logic [ANGLE_BITS+YAW_BITS-1:0] yaw_wide;
	logic [ANGLE_BITS-1:0] ang;
	logic [1:0] quad;
	logic [PHASE_BITS+IDX_BITS-1:0] phase_prod;
	logic [IDX_BITS-1:0] idx_raw;
	logic [IDX_BITS-1:0] idx_mirror;

	logic [IDX_BITS-1:0] sin_idx_s1, cos_idx_s1;
	logic sin_neg_s1, cos_neg_s1;
	logic signed [AXIS_BITS-1:0] fwd_s1, lat_s1, rot_s1;

	logic [SINE_BITS-1:0] sin_mag_s2, cos_mag_s2;
	logic sin_neg_s2, cos_neg_s2;
	logic signed [AXIS_BITS-1:0] fwd_s2, lat_s2, rot_s2;

	logic signed [TRIG_BITS-1:0] sn, cs;
	logic signed [PROD_BITS-1:0] fc_s3, ls_s3, lc_s3, fs_s3;
	logic signed [SPIN_BITS-1:0] spin_s3;

	assign yaw_wide = {yaw_angle, {ANGLE_BITS{1'b0}}};
	assign ang = yaw_wide[ANGLE_BITS+YAW_BITS-1:YAW_BITS];
	assign quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
	assign phase_prod = {{IDX_BITS{1'b0}}, ang[PHASE_BITS-1:0]}
		* (PHASE_BITS+IDX_BITS)'(SINE_TABLE_DEPTH);
	assign idx_raw = phase_prod[PHASE_BITS+IDX_BITS-1:PHASE_BITS];
	assign idx_mirror = IDX_BITS'(SINE_TABLE_DEPTH) - idx_raw;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			sin_idx_s1 <= quad[0] ? idx_mirror : idx_raw;
			cos_idx_s1 <= quad[0] ? idx_raw : idx_mirror;
			sin_neg_s1 <= quad[1];
			cos_neg_s1 <= quad[1] ^ quad[0];
			fwd_s1 <= -AXIS_BITS'(stick_forward);
			lat_s1 <= AXIS_BITS'(stick_lateral);
			rot_s1 <= {stick_turn, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			sin_mag_s2 <= SINE_ROM[sin_idx_s1];
			cos_mag_s2 <= SINE_ROM[cos_idx_s1];
			sin_neg_s2 <= sin_neg_s1;
			cos_neg_s2 <= cos_neg_s1;
			fwd_s2 <= fwd_s1;
			lat_s2 <= lat_s1;
			rot_s2 <= rot_s1;
		end
	end

	assign sn = sin_neg_s2 ? -$signed({1'b0, sin_mag_s2}) : $signed({1'b0, sin_mag_s2});
	assign cs = cos_neg_s2 ? -$signed({1'b0, cos_mag_s2}) : $signed({1'b0, cos_mag_s2});

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			fc_s3 <= fwd_s2 * cs;
			ls_s3 <= lat_s2 * sn;
			lc_s3 <= lat_s2 * cs;
			fs_s3 <= fwd_s2 * sn;
			spin_s3 <= rot_s2 * $signed({1'b0, wheel_radius_factor});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			vx_s4 <= fc_s3 + ls_s3;
			vy_s4 <= lc_s3 - fs_s3;
			spin_s4 <= spin_s3;
		end
	end

endmodule

FILE: sv/hlom_lane.sv
module hlom_lane import hlom_pkg::*; (
	input  logic                          clk,
	input  stage_ctl_t                    ctl,
	input  logic                          neg_x,
	input  logic                          neg_y,
	input  logic signed [VEL_BITS-1:0]    vx_s4,
	input  logic signed [VEL_BITS-1:0]    vy_s4,
	input  logic signed [SPIN_BITS-1:0]   spin_s4,
	input  logic [CFG_BITS-1:0]           inv_wheel_spacing,
	output logic signed [SPEED_BITS-1:0]  speed_s10
);

	localparam logic [MAG_BITS-1:0] ROUND_HALF = MAG_BITS'(1) << (ROUND_SHIFT - 1);

	logic signed [MIX_BITS-1:0] x_term, y_term, mix;
	logic signed [KPROD_BITS-1:0] kp_s5;
	logic signed [SPIN_BITS-1:0] spin_s5;
	logic signed [SUM_BITS-1:0] w_s6;
	logic [LO_PROD_BITS-1:0] lo_p_s7;
	logic signed [HI_PROD_BITS-1:0] hi_p_s7;
	logic signed [FULL_BITS-1:0] full_s8;
	logic neg_s9;
	logic [MAG_BITS-1:0] mag_s9;
	logic signed [FULL_BITS-1:0] full_abs;
	logic [MAG_BITS:0] rounded;
	logic [QUOT_BITS-1:0] quot;

	assign x_term = neg_x ? -MIX_BITS'(vx_s4) : MIX_BITS'(vx_s4);
	assign y_term = neg_y ? -MIX_BITS'(vy_s4) : MIX_BITS'(vy_s4);
	assign mix = x_term + y_term;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			kp_s5 <= mix * MIX_K_Q15;
			spin_s5 <= spin_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			w_s6 <= SUM_BITS'(kp_s5) + (SUM_BITS'(spin_s5) <<< SPIN_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			lo_p_s7 <= w_s6[LO_BITS-1:0] * inv_wheel_spacing;
			hi_p_s7 <= $signed(w_s6[SUM_BITS-1:LO_BITS]) * $signed({1'b0, inv_wheel_spacing});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			full_s8 <= (FULL_BITS'(hi_p_s7) <<< LO_BITS)
				+ $signed({{(FULL_BITS-LO_PROD_BITS){1'b0}}, lo_p_s7});
		end
	end

	assign full_abs = full_s8[FULL_BITS-1] ? -full_s8 : full_s8;

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			neg_s9 <= full_s8[FULL_BITS-1];
			mag_s9 <= full_abs[MAG_BITS-1:0];
		end
	end

	assign rounded = {1'b0, mag_s9} + {1'b0, ROUND_HALF};
	assign quot = rounded[MAG_BITS:ROUND_SHIFT];

	always_ff @(posedge clk) begin
		if (ctl.load[9]) begin
			priority if (!neg_s9 && quot > QUOT_BITS'(32767)) begin
				speed_s10 <= 16'sh7FFF;
			end else if (neg_s9 && quot > QUOT_BITS'(32768)) begin
				speed_s10 <= -16'sh8000;
			end else if (neg_s9) begin
				speed_s10 <= -SPEED_BITS'(quot);
			end else begin
				speed_s10 <= SPEED_BITS'(quot);
			end
		end
	end

endmodule

FILE: sv/heading_locked_omni_wheel_mixer_unit.sv
// Heading-locked mixer for a four-wheel omni chassis. Each word on stick carries the three
// stick channels and the yaw angle; the matching word on setpoint carries the four rounded and
// saturated wheel speed setpoints. The block takes one word per clock while setpoint is not
// stalled and returns each result in the order the words were taken. The depth is set by the
// sine table read, the rotation products and the wide product with the spacing reciprocal,
// which is done in two partial products over two stages. Each stage holds its word under
// backpressure, so empty stages still fill while the output waits. The sine and cosine come
// from one quarter-wave table of 1025 entries read at two addresses in the same cycle. The
// two registers are written through write_enable, reg_index and write_data and must only be
// changed while no word is in flight.
module heading_locked_omni_wheel_mixer_unit import hlom_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	hlom_in_if.sink             stick,
	hlom_out_if.source          setpoint,
	input  logic                write_enable,
	input  logic                reg_index,
	input  logic [CFG_BITS-1:0] write_data
);

	logic [CFG_BITS-1:0] wheel_radius_factor_q;
	logic [CFG_BITS-1:0] inv_wheel_spacing_q;
	stage_ctl_t ctl;
	logic signed [VEL_BITS-1:0] vx_s4, vy_s4;
	logic signed [SPIN_BITS-1:0] spin_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_factor_q <= RADIUS_RESET;
			inv_wheel_spacing_q <= INV_SPACING_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_WHEEL_RADIUS: wheel_radius_factor_q <= write_data;
				REG_INV_SPACING: inv_wheel_spacing_q <= write_data;
				default: ;
			endcase
		end
	end

	hlom_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(stick.valid),
		.out_ready(setpoint.ready),
		.in_ready(stick.ready),
		.ctl(ctl)
	);

	hlom_rotate u_rotate (
		.clk(clk),
		.ctl(ctl),
		.stick_forward(stick.stick_forward),
		.stick_lateral(stick.stick_lateral),
		.stick_turn(stick.stick_turn),
		.yaw_angle(stick.yaw_angle),
		.wheel_radius_factor(wheel_radius_factor_q),
		.vx_s4(vx_s4),
		.vy_s4(vy_s4),
		.spin_s4(spin_s4)
	);

	hlom_lane u_lane_one (
		.clk(clk), .ctl(ctl), .neg_x(1'b1), .neg_y(1'b0),
		.vx_s4(vx_s4), .vy_s4(vy_s4), .spin_s4(spin_s4),
		.inv_wheel_spacing(inv_wheel_spacing_q),
		.speed_s10(setpoint.wheel_one_speed)
	);

	hlom_lane u_lane_two (
		.clk(clk), .ctl(ctl), .neg_x(1'b1), .neg_y(1'b1),
		.vx_s4(vx_s4), .vy_s4(vy_s4), .spin_s4(spin_s4),
		.inv_wheel_spacing(inv_wheel_spacing_q),
		.speed_s10(setpoint.wheel_two_speed)
	);

	hlom_lane u_lane_three (
		.clk(clk), .ctl(ctl), .neg_x(1'b0), .neg_y(1'b1),
		.vx_s4(vx_s4), .vy_s4(vy_s4), .spin_s4(spin_s4),
		.inv_wheel_spacing(inv_wheel_spacing_q),
		.speed_s10(setpoint.wheel_three_speed)
	);

	hlom_lane u_lane_four (
		.clk(clk), .ctl(ctl), .neg_x(1'b0), .neg_y(1'b0),
		.vx_s4(vx_s4), .vy_s4(vy_s4), .spin_s4(spin_s4),
		.inv_wheel_spacing(inv_wheel_spacing_q),
		.speed_s10(setpoint.wheel_four_speed)
	);

	assign setpoint.valid = ctl.valid[NUM_STAGES-1];

endmodule

FILE: sv/hlom_checker.sv
module hlom_checker import hlom_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [SPEED_BITS-1:0] speed_one,
	input logic signed [SPEED_BITS-1:0] speed_two,
	input logic signed [SPEED_BITS-1:0] speed_three,
	input logic signed [SPEED_BITS-1:0] speed_four,
	input logic                         write_enable,
	input logic                         reg_index,
	input logic [CFG_BITS-1:0]          write_data
);

	logic [4:0] in_flight_q;
	logic [CFG_BITS-1:0] inv_shadow_q;
	logic in_fire, out_fire;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
			inv_shadow_q <= INV_SPACING_RESET;
		end else begin
			in_flight_q <= in_flight_q + 5'(in_fire) - 5'(out_fire);
			if (write_enable && reg_index == REG_INV_SPACING) begin
				inv_shadow_q <= write_data;
			end
		end
	end

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> in_ready && !out_valid)
		else $error("Pipeline not empty after reset.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_one) && $stable(speed_two)
			&& $stable(speed_three) && $stable(speed_four))
		else $error("Stalled result word changed.");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> in_flight_q != 5'd0)
		else $error("Result word without an accepted input word.");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= 5'(NUM_STAGES))
		else $error("More words in flight than pipeline stages.");

	a_zero_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inv_shadow_q == '0 |-> speed_one == '0 && speed_two == '0
			&& speed_three == '0 && speed_four == '0)
		else $error("Nonzero wheel speed with zero spacing reciprocal.");

endmodule

bind heading_locked_omni_wheel_mixer_unit hlom_checker u_hlom_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(stick.valid),
	.in_ready(stick.ready),
	.out_valid(setpoint.valid),
	.out_ready(setpoint.ready),
	.speed_one(setpoint.wheel_one_speed),
	.speed_two(setpoint.wheel_two_speed),
	.speed_three(setpoint.wheel_three_speed),
	.speed_four(setpoint.wheel_four_speed),
	.write_enable(write_enable),
	.reg_index(reg_index),
	.write_data(write_data)
);
